// ===== rtl/sdx_pkg.sv =====
`default_nettype none

package sdx_pkg;

  // Character and code widths
  localparam int unsigned CharW = 8;
  localparam int unsigned LenW  = 3;

  typedef logic [CharW-1:0] char_t;
  typedef logic [LenW-1:0]  len_t;

  // Code length minimum and reset value
  localparam len_t LenMin   = len_t'(4);
  localparam len_t LenReset = len_t'(4);

  // ASCII and Latin-1 codes used by the encoder
  localparam char_t ChZero    = 8'h30;  // '0'
  localparam char_t ChSix     = 8'h36;  // '6'
  localparam char_t ChUpperA  = 8'h41;
  localparam char_t ChUpperZ  = 8'h5A;
  localparam char_t ChLowerA  = 8'h61;
  localparam char_t ChLowerZ  = 8'h7A;
  localparam char_t ChFemOrd  = 8'hAA;
  localparam char_t ChMicro   = 8'hB5;
  localparam char_t ChMascOrd = 8'hBA;
  localparam char_t ChLatinLo = 8'hC0;
  localparam char_t ChTimes   = 8'hD7;
  localparam char_t ChSmallLo = 8'hE0;
  localparam char_t ChSmallHi = 8'hFE;
  localparam char_t ChDivide  = 8'hF7;
  localparam char_t CaseDelta = 8'h20;

  // Soundex-style digit for A..Z; L gives 5, M and N give 4, unlike classic Soundex
  localparam char_t DigitOf [26] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h30, 8'h31, 8'h32, 8'h30, 8'h30, 8'h32,
    8'h32, 8'h35, 8'h34, 8'h34, 8'h30, 8'h31, 8'h32, 8'h36, 8'h32, 8'h33,
    8'h30, 8'h31, 8'h30, 8'h32, 8'h30, 8'h32
  };

  // Latin-1 upper-case fold
  function automatic char_t fold_upper(input char_t c);
    char_t r;
    r = c;
    if ((c >= ChLowerA && c <= ChLowerZ) ||
        (c >= ChSmallLo && c <= ChSmallHi && c != ChDivide)) begin
      r = c - CaseDelta;
    end
    return r;
  endfunction

  // Letter test on a folded character
  function automatic logic is_letter(input char_t c);
    return (c >= ChUpperA && c <= ChUpperZ) || c == ChFemOrd || c == ChMicro ||
           c == ChMascOrd || (c >= ChLatinLo && c != ChTimes && c != ChDivide);
  endfunction

  // Digit for a folded letter
  function automatic char_t letter_digit(input char_t c);
    char_t r;
    char_t off;
    r   = ChSix;
    off = c - ChUpperA;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r = DigitOf[off[4:0]];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sdx_channels.sv =====
`default_nettype none

// Character stream channel
interface sdx_in_if;
  logic               valid;
  logic               ready;
  sdx_pkg::char_t     char_in;
  logic               word_end;

  modport source (output valid, output char_in, output word_end, input ready);
  modport sink   (input valid, input char_in, input word_end, output ready);
endinterface

// Code character channel
interface sdx_out_if;
  logic               valid;
  logic               ready;
  sdx_pkg::char_t     code_char;
  logic               code_last;

  modport source (output valid, output code_char, output code_last, input ready);
  modport sink   (input valid, input code_char, input code_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/soundex_phonetic_encoder_unit.sv =====
`default_nettype none

// Channel    Dir  Payload                      Transfer
// in_chan    in   char_in[7:0], word_end       valid & ready
// out_chan   out  code_char[7:0], code_last    valid & ready
// cfg        in   cfg_wdata[2:0] (code length) cfg_we
//
// One character per cycle while in_chan.ready is high; a character yields at
// most one code character in the cycle it is taken, registered in the output
// stage. At word end, trailing '0' padding leaves from a down counter, one per
// cycle while the output slot is free; input waits until the padding is out.
// in_chan.ready follows out_chan.ready combinationally through the output stage.
// Synchronous active-low reset clears word state; code length resets to 4.
module soundex_phonetic_encoder_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  sdx_in_if.sink              in_chan,
  sdx_out_if.source           out_chan,
  input  wire logic           cfg_we,
  input  wire sdx_pkg::len_t  cfg_wdata
);
  import sdx_pkg::*;

  len_t  code_length_r;
  char_t prev_char_r,  prev_char_nxt;
  logic  in_word_r,    in_word_nxt;
  len_t  count_r,      count_nxt;
  len_t  pad_left_r,   pad_left_nxt;
  logic  out_valid_r,  out_valid_nxt;
  char_t out_char_r,   out_char_nxt;
  logic  out_last_r,   out_last_nxt;

  logic  slot_free;
  logic  in_xfer;
  char_t c_fold;
  len_t  len_eff;
  logic  emit;
  char_t emit_char;
  len_t  count_mid;
  len_t  pad_cnt;

  // Output slot frees when empty or being drained
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = slot_free && (pad_left_r == '0);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.code_char = out_char_r;
  assign out_chan.code_last = out_last_r;

  // Character classification
  assign c_fold  = fold_upper(in_chan.char_in);
  assign len_eff = (code_length_r < LenMin) ? LenMin : code_length_r;

  // Per-character emission
  always_comb begin
    emit          = 1'b0;
    emit_char     = c_fold;
    count_mid     = count_r;
    prev_char_nxt = prev_char_r;
    if (!in_word_r) begin
      emit          = 1'b1;
      count_mid     = len_t'(1);
      prev_char_nxt = c_fold;
    end else if (c_fold != prev_char_r) begin
      prev_char_nxt = c_fold;
      if (is_letter(c_fold) && count_r < len_eff) begin
        emit      = 1'b1;
        emit_char = letter_digit(c_fold);
        count_mid = count_r + len_t'(1);
      end
    end
    // word end clears the compare reference
    if (in_chan.word_end) begin
      prev_char_nxt = '0;
    end
    pad_cnt = (in_chan.word_end && count_mid < len_eff) ? (len_eff - count_mid) : '0;
  end

  // Next state for word, padding and output stage
  always_comb begin
    in_word_nxt   = in_word_r;
    count_nxt     = count_r;
    pad_left_nxt  = pad_left_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (in_xfer) begin
      if (in_chan.word_end) begin
        in_word_nxt = 1'b0;
        count_nxt   = '0;
      end else begin
        in_word_nxt = 1'b1;
        count_nxt   = count_mid;
      end
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = emit_char;
        pad_left_nxt  = pad_cnt;
        out_last_nxt  = (pad_cnt == '0) && (count_mid >= len_eff);
      end else if (pad_cnt != '0) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ChZero;
        pad_left_nxt  = pad_cnt - len_t'(1);
        out_last_nxt  = (pad_cnt == len_t'(1));
      end
    end else if (pad_left_r != '0 && slot_free) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ChZero;
      pad_left_nxt  = pad_left_r - len_t'(1);
      out_last_nxt  = (pad_left_r == len_t'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= LenReset;
      prev_char_r   <= '0;
      in_word_r     <= 1'b0;
      count_r       <= '0;
      pad_left_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        code_length_r <= cfg_wdata;
      end
      if (in_xfer) begin
        prev_char_r <= prev_char_nxt;
      end
      in_word_r   <= in_word_nxt;
      count_r     <= count_nxt;
      pad_left_r  <= pad_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/tb_soundex_phonetic_encoder_unit.sv =====
`default_nettype none

module tb_soundex_phonetic_encoder_unit;
  import sdx_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 16;
  localparam int HoldCycles = 300;
  localparam int NumPhases = 8;

  // One character of a word as offered on the input channel
  typedef struct packed {
    char_t ch;
    logic  fin;
  } word_char_t;

  // One code character as expected on the result channel
  typedef struct packed {
    char_t ch;
    logic  last;
  } code_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  len_t cfg_wdata;

  sdx_in_if  in_chan_if ();
  sdx_out_if out_chan_if ();

  soundex_phonetic_encoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Pending word characters and expected code characters
  word_char_t char_q [$];
  code_t      code_q [$];

  // Encoder state mirror
  char_t word_prev;
  logic  word_open;
  int    word_count;
  len_t  code_len;

  int  src_idle_pct;
  int  sink_stall_pct;
  logic recv_hold;
  logic in_taken;
  int  cycle_cnt;
  int  errors;
  int  chars_sent;
  int  codes_seen;
  int  len_writes;
  event hold_go;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Latin-1 upper-case fold
  function automatic char_t upcase(input char_t c);
    if ((c >= "a" && c <= "z") || (c >= 8'hE0 && c <= 8'hFE && c != 8'hF7)) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Letter test on a folded character
  function automatic bit is_alpha(input char_t c);
    if (c >= "A" && c <= "Z") return 1'b1;
    if (c == 8'hAA || c == 8'hB5 || c == 8'hBA) return 1'b1;
    return c >= 8'hC0 && c != 8'hD7 && c != 8'hF7;
  endfunction

  // Soundex digit of a folded letter; non-ASCII letters map to six
  function automatic char_t sdx_digit(input char_t c);
    case (c)
      "B", "F", "P", "V":                     return "1";
      "C", "G", "J", "K", "Q", "S", "X", "Z": return "2";
      "D", "T":                               return "3";
      "M", "N":                               return "4";
      "L":                                    return "5";
      "R":                                    return "6";
      default: begin
        if (c >= "A" && c <= "Z") return "0";
        return "6";
      end
    endcase
  endfunction

  // Work out the code characters one input character causes
  task automatic predict_codes(input char_t raw, input logic fin);
    code_t outs [8];
    char_t c;
    int lim;
    int cnt;
    int n;
    c = upcase(raw);
    lim = (code_len < 4) ? 4 : int'(code_len);
    cnt = word_count;
    n = 0;
    if (!word_open) begin
      outs[0] = '{ch: c, last: 1'b0};
      n = 1;
      cnt = 1;
      word_prev = c;
      word_open = 1'b1;
    end else if (c != word_prev) begin
      word_prev = c;
      if (is_alpha(c) && cnt < lim) begin
        outs[n] = '{ch: sdx_digit(c), last: 1'b0};
        n++;
        cnt++;
      end
    end
    // zero padding at word end
    if (fin) begin
      while (cnt < lim) begin
        outs[n] = '{ch: "0", last: 1'b0};
        n++;
        cnt++;
      end
    end
    if (n > 0 && cnt >= lim) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) code_q.push_back(outs[i]);
    if (fin) begin
      word_open = 1'b0;
      word_count = 0;
      word_prev = '0;
    end else begin
      word_count = cnt & 7;
    end
  endtask

  // Input driver: holds valid until the transfer, idles at random otherwise
  always @(negedge clk) begin : drive_chars
    word_char_t nxt;
    if (!rst_n) begin
      in_chan_if.valid <= 1'b0;
    end else if (!in_chan_if.valid || in_taken) begin
      if (in_taken) char_q.delete(0);
      if (char_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = char_q[0];
        in_chan_if.valid    <= 1'b1;
        in_chan_if.char_in  <= nxt.ch;
        in_chan_if.word_end <= nxt.fin;
      end else begin
        in_chan_if.valid <= 1'b0;
      end
    end
  end

  // Result ready with random stalls and the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan_if.ready <= 1'b0;
    end else begin
      out_chan_if.ready <= !recv_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Long receiver hold-off, counted here
  always begin
    @(hold_go);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    recv_hold = 1'b0;
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin : check_codes
    code_t got;
    code_t want;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes outstanding", cycle_cnt, code_q.size());
      $display("soundex_phonetic_encoder_unit: mismatch");
      $finish;
    end else begin
      in_taken <= rst_n && in_chan_if.valid && in_chan_if.ready;
      if (rst_n && in_chan_if.valid && in_chan_if.ready) begin
        predict_codes(in_chan_if.char_in, in_chan_if.word_end);
        chars_sent++;
      end
      if (rst_n && out_chan_if.valid && out_chan_if.ready) begin
        got = '{ch: out_chan_if.code_char, last: out_chan_if.code_last};
        codes_seen++;
        if (code_q.size() == 0) begin
          if (errors < 10) $display("unexpected code char %h last %b", got.ch, got.last);
          errors++;
        end else begin
          want = code_q.pop_front();
          if (got.ch !== want.ch || got.last !== want.last) begin
            if (errors < 10) begin
              $display("code %0d: expected char %h last %b, got char %h last %b",
                       codes_seen, want.ch, want.last, got.ch, got.last);
            end
            errors++;
          end
        end
      end
    end
  end

  task automatic push_char(input char_t ch, input logic fin);
    char_q.push_back('{ch: ch, fin: fin});
  endtask

  // Wait until every character is taken and every code has arrived
  task automatic drain();
    @(posedge clk);
    #1;
    while (!(char_q.size() == 0 && !in_chan_if.valid && code_q.size() == 0)) begin
      @(posedge clk);
      #1;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Code length write while idle
  task automatic set_len(input len_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    code_len = v;
    len_writes++;
  endtask

  // Random character, biased toward letters and repeats
  function automatic char_t pick_char(input char_t prev);
    int r;
    r = $urandom_range(99);
    if (r < 40) return char_t'($urandom_range("z", "a"));
    if (r < 60) return char_t'($urandom_range("Z", "A"));
    if (r < 72) return char_t'($urandom_range(8'hFF, 8'hC0));
    if (r < 88) return char_t'($urandom_range(255));
    if (r < 94) return prev ^ 8'h20;
    return prev;
  endfunction

  // Whole random words until about n characters are queued
  task automatic add_words(input int n_items);
    int k;
    int wl;
    char_t ch;
    char_t prev;
    k = 0;
    while (k < n_items) begin
      wl = (($urandom_range(9) == 0) ? 1 : $urandom_range(10, 2));
      prev = "A";
      for (int i = 0; i < wl; i++) begin
        ch = pick_char(prev);
        push_char(ch, i == wl - 1);
        prev = ch;
      end
      k += wl;
    end
  endtask

  initial begin
    len_t ph_len  [NumPhases];
    int   ph_src  [NumPhases];
    int   ph_sink [NumPhases];
    ph_len  = '{3'd7, 3'd5, 3'd6, 3'd2, 3'd7, 3'd1, 3'd3, 3'd0};
    ph_src  = '{0, 85, 0, 25, 0, 25, 85, 0};
    ph_sink = '{0, 0, 85, 25, 0, 25, 0, 85};
    in_chan_if.valid    = 1'b0;
    in_chan_if.char_in  = '0;
    in_chan_if.word_end = 1'b0;
    out_chan_if.ready   = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    recv_hold = 1'b0;
    in_taken  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    cycle_cnt  = 0;
    errors     = 0;
    chars_sent = 0;
    codes_seen = 0;
    len_writes = 0;
    word_prev  = '0;
    word_open  = 1'b0;
    word_count = 0;
    code_len   = LenReset;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset length, full code then ignored tail
    push_char("r", 1'b0); push_char("o", 1'b0); push_char("b", 1'b0);
    push_char("e", 1'b0); push_char("r", 1'b0); push_char("t", 1'b1);
    // word end on first character, accented letter folds
    push_char(8'hE9, 1'b1);
    // duplicate dropped, non-letter as compare reference, non-ASCII digit
    push_char("b", 1'b0); push_char("B", 1'b0); push_char("1", 1'b0);
    push_char("b", 1'b0); push_char(8'hFF, 1'b1);
    // zero byte first, then non-letter symbols, a no-fold letter and a lower-case one
    push_char(8'h00, 1'b0); push_char(8'hF7, 1'b0); push_char(8'hD7, 1'b0);
    push_char(8'hAA, 1'b0); push_char(8'h7A, 1'b1);
    drain();

    // Longest code, then a length cut in mid-word
    set_len(3'd7);
    push_char("z", 1'b0); push_char(8'hBA, 1'b1);
    push_char("k", 1'b0); push_char("l", 1'b0); push_char("m", 1'b0);
    push_char("n", 1'b0);
    drain();
    set_len(3'd4);
    push_char("p", 1'b0); push_char(8'hDF, 1'b1);
    drain();

    // Random phases with varied idling and lengths
    for (int p = 0; p < NumPhases; p++) begin
      set_len(ph_len[p]);
      src_idle_pct   = ph_src[p];
      sink_stall_pct = ph_sink[p];
      if (p == 4) ->hold_go;
      add_words(40);
      drain();
    end

    $display("sent %0d characters, checked %0d code characters", chars_sent, codes_seen);
    $display("%0d code length writes, lengths 0..7, idle and long stall phases", len_writes);
    if (errors == 0 && code_q.size() == 0) begin
      $display("soundex_phonetic_encoder_unit: match");
    end else begin
      $display("%0d mismatches, %0d codes outstanding", errors, code_q.size());
      $display("soundex_phonetic_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/sdx_pkg.sv
rtl/sdx_channels.sv
rtl/soundex_phonetic_encoder_unit.sv
tb/tb_soundex_phonetic_encoder_unit.sv
